### hdl/positional_array_list_macros.svh
// Assertion macros for the positional array list checker.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// check a property on every rising clock edge outside reset
`define PAL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);

// check that a condition implies another one in the following cycle
`define PAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pal_pkg.sv
// Shared types for the positional array list.
`default_nettype none

package pal_pkg;

  typedef enum logic [2:0] {
    FUNC_READ   = 3'd0,
    FUNC_WRITE  = 3'd1,
    FUNC_INSERT = 3'd2,
    FUNC_REMOVE = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
    logic sel;
    logic after;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/positional_array_list.sv
// Positional array list: a row of entry cells with insert/remove shifting.
// The result word of an accepted word is registered and is valid in the cycle after it.
// One word is accepted per cycle unless the input stalls; all cells shift in parallel.
// Input stalls only while a result word is held by a stalled output.
// Reset clears the count and the output valid; entry contents are not reset.
`default_nettype none

module positional_array_list import pal_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         func_i,
  input  wire logic [7:0]         position_i,
  input  wire logic signed [31:0] data_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    ok_o,
  output logic signed [31:0]      read_data_o,
  output logic [4:0]              length_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q;
  logic               ok_q;
  logic signed [31:0] read_data_q;
  logic [4:0]         length_q;
  logic               empty_q, full_q;

  logic               accept;
  logic [7:0]         idx;
  logic               pos_hit, pos_ins, room;
  logic               ok_d, do_ins, do_rem, do_wr;
  logic signed [31:0] tap_or, rd_d;
  logic [31:0]        count_ext;

  logic signed [31:0] vals    [CAPACITY];
  logic signed [31:0] taps    [CAPACITY];
  logic signed [31:0] left_w  [CAPACITY];
  logic signed [31:0] right_w [CAPACITY];
  cell_ctrl_t         ctrl_w  [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign idx        = position_i - 8'd1;

  assign pos_hit = (position_i != 8'd0) && (9'(position_i) <= 9'(count_q));
  assign pos_ins = (position_i != 8'd0) && (9'(position_i) <= 9'(count_q) + 9'd1);
  assign room    = 9'(count_q) < 9'(CAPACITY);

  always_comb begin
    ok_d   = 1'b0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_wr  = 1'b0;
    case (func_e'(func_i))
      FUNC_READ: begin
        ok_d = pos_hit;
      end
      FUNC_WRITE: begin
        ok_d  = pos_hit;
        do_wr = accept && pos_hit;
      end
      FUNC_INSERT: begin
        ok_d   = room && pos_ins;
        do_ins = accept && room && pos_ins;
      end
      FUNC_REMOVE: begin
        ok_d   = pos_hit;
        do_rem = accept && pos_hit;
      end
      FUNC_CLEAR: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_rem) begin
      count_d = count_q - CntW'(1);
    end else if (accept && func_e'(func_i) == FUNC_CLEAR) begin
      count_d = '0;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_left
      assign left_w[g] = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_right
      assign right_w[g] = vals[g+1];
    end

    assign ctrl_w[g] = '{
      ins:   do_ins,
      rem:   do_rem,
      wr:    do_wr,
      sel:   (idx == 8'(g)),
      after: (8'(g) > idx)
    };

    pal_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_w[g]),
      .data_i  (data_in_i),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .value_o (vals[g]),
      .tap_o   (taps[g])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  assign rd_d      = (func_e'(func_i) == FUNC_READ && pos_hit) ? tap_or : '0;
  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q        <= ok_d;
      read_data_q <= rd_d;
      length_q    <= count_ext[4:0];
      empty_q     <= (count_d == '0);
      full_q      <= (count_d == CntW'(CAPACITY));
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign read_data_o = read_data_q;
  assign length_o    = length_q;
  assign is_empty_o  = empty_q;
  assign is_full_o   = full_q;

endmodule

`default_nettype wire

### hdl/pal_cell.sv
// One storage cell of the list: holds an entry and shifts with its neighbors.
`default_nettype none

module pal_cell import pal_pkg::*; (
  input  wire logic               clk_i,
  input  wire cell_ctrl_t         ctrl_i,
  input  wire logic signed [31:0] data_i,
  input  wire logic signed [31:0] left_i,
  input  wire logic signed [31:0] right_i,
  output logic signed [31:0]      value_o,
  output logic signed [31:0]      tap_o
);

  logic signed [31:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (ctrl_i.sel) begin
        value_d = data_i;
      end else if (ctrl_i.after) begin
        value_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      if (ctrl_i.sel || ctrl_i.after) begin
        value_d = right_i;
      end
    end else if (ctrl_i.wr && ctrl_i.sel) begin
      value_d = data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign tap_o   = ctrl_i.sel ? value_q : '0;

endmodule

`default_nettype wire

### hdl/pal_checker.sv
// Port-level assertions for the positional array list, bound to the top level.
`default_nettype none

`include "positional_array_list_macros.svh"

module pal_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               ok_o,
  input wire logic signed [31:0] read_data_o,
  input wire logic [4:0]         length_o,
  input wire logic               is_empty_o,
  input wire logic               is_full_o
);

  `PAL_ASSERT(a_stall_needs_word, clk_i, rst_ni, in_stall_o |-> out_valid_o, "stall without word")
  `PAL_ASSERT(a_refused_zero, clk_i, rst_ni, (out_valid_o && !ok_o) |-> (read_data_o == '0), "refused read data")
  `PAL_ASSERT(a_empty_len, clk_i, rst_ni, (out_valid_o && is_empty_o) |-> (length_o == 5'd0), "empty length")
  `PAL_ASSERT(a_not_both, clk_i, rst_ni, out_valid_o |-> !(is_empty_o && is_full_o), "empty and full")
  `PAL_ASSERT_NEXT(a_hold_word, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(read_data_o), "word dropped")

endmodule

bind positional_array_list pal_checker u_pal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .ok_o        (ok_o),
  .read_data_o (read_data_o),
  .length_o    (length_o),
  .is_empty_o  (is_empty_o),
  .is_full_o   (is_full_o)
);

`default_nettype wire
